@@ rtl/dtm_pkg.sv @@
// Package for the dual trimmed-mean window filter.
// Holds the sample width, the default window length and the reciprocal scale
// shared by the cells, tree nodes, dividers and the top level. No dependencies.
package dtm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int WINDOW_DEF = 8;
  // Fraction bits of the fixed-point reciprocal used by the constant divider.
  localparam int MUL_SH     = 24;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

@@ rtl/dual_trimmed_mean_window_top.sv @@
// Top level of the dual trimmed-mean window filter.
// Depends on dtm_pkg, dtm_cell, dtm_node and dtm_div.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   in_front_sample, in_rear_sample
//   out_     output     out_valid/out_stall out_front_filtered, out_rear_filtered
//
// The block takes one beat per cycle while in_stall is low and returns one result beat per input beat.
// From acceptance to out_valid a beat passes through one window cell load,
// $clog2(WINDOW) registered tree levels, the trim subtraction, the reciprocal
// multiply and the correction stage, whose register is the output register.
// Synchronous reset clears the window cells to zero and empties every stage.
// Each stage holds its beat only while the stage after it is full and blocked,
// so out_stall backs up through the bubbles before in_stall rises.
module dual_trimmed_mean_window_top import dtm_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t in_front_sample,
  input  sample_t in_rear_sample,
  output logic    out_valid,
  input  logic    out_stall,
  output sample_t out_front_filtered,
  output sample_t out_rear_filtered
);

  localparam int LVL   = $clog2(WINDOW);
  localparam int NLEAF = 1 << LVL;
  localparam int SUM_W = SAMPLE_W + LVL;
  // Stages: window, tree levels, trim, multiply, output.
  localparam int NST   = LVL + 4;
  localparam int ST_REST = LVL + 1;
  localparam int ST_MUL  = LVL + 2;
  localparam int ST_OUT  = LVL + 3;

  logic [NST-1:0] v_r, v_nxt;
  logic [NST-1:0] stage_rdy;
  logic           accept;

  // Ready travels backward: a stage can load when it is empty or drains.
  always_comb begin
    stage_rdy[NST-1] = !v_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      stage_rdy[i] = !v_r[i] || stage_rdy[i+1];
    end
  end

  assign accept   = in_valid && stage_rdy[0];
  assign in_stall = !stage_rdy[0];

  always_comb begin
    v_nxt = v_r;
    if (stage_rdy[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < NST; i++) begin
      if (stage_rdy[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // The window is a chain of cells; index 0 holds the oldest sample and every
  // accepted beat moves each entry one cell toward it.
  sample_t win [2][WINDOW];

  for (genvar c = 0; c < WINDOW; c++) begin : g_cell
    if (c == WINDOW - 1) begin : g_last
      dtm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (accept),
        .d_front (in_front_sample),
        .d_rear  (in_rear_sample),
        .q_front (win[0][c]),
        .q_rear  (win[1][c])
      );
    end else begin : g_mid
      dtm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (accept),
        .d_front (win[0][c+1]),
        .d_rear  (win[1][c+1]),
        .q_front (win[0][c]),
        .q_rear  (win[1][c])
      );
    end
  end

  // Reduction tree stored as a heap: node k has children 2k and 2k+1, leaves
  // start at NLEAF. Padding leaves are neutral for sum, minimum and maximum.
  logic [SUM_W-1:0] t_sum [2][1:2*NLEAF-1];
  sample_t          t_min [2][1:2*NLEAF-1];
  sample_t          t_max [2][1:2*NLEAF-1];
  logic [SUM_W-1:0] rest_r [2];
  sample_t          quot [2];

  for (genvar ch = 0; ch < 2; ch++) begin : g_ch
    for (genvar k = 0; k < NLEAF; k++) begin : g_leaf
      if (k < WINDOW) begin : g_real
        assign t_sum[ch][NLEAF+k] = SUM_W'(win[ch][k]);
        assign t_min[ch][NLEAF+k] = win[ch][k];
        assign t_max[ch][NLEAF+k] = win[ch][k];
      end else begin : g_pad
        assign t_sum[ch][NLEAF+k] = '0;
        assign t_min[ch][NLEAF+k] = '1;
        assign t_max[ch][NLEAF+k] = '0;
      end
    end

    for (genvar j = 0; j < LVL; j++) begin : g_lvl
      for (genvar k = (1 << j); k < (2 << j); k++) begin : g_node
        dtm_node #(.SUM_W(SUM_W)) u_node (
          .clk   (clk),
          .en    (stage_rdy[LVL-j]),
          .a_sum (t_sum[ch][2*k]),
          .a_min (t_min[ch][2*k]),
          .a_max (t_max[ch][2*k]),
          .b_sum (t_sum[ch][2*k+1]),
          .b_min (t_min[ch][2*k+1]),
          .b_max (t_max[ch][2*k+1]),
          .q_sum (t_sum[ch][k]),
          .q_min (t_min[ch][k]),
          .q_max (t_max[ch][k])
        );
      end
    end

    // Drop one instance of the minimum and one of the maximum.
    always_ff @(posedge clk) begin
      if (stage_rdy[ST_REST]) begin
        rest_r[ch] <= t_sum[ch][1] - SUM_W'(t_min[ch][1]) - SUM_W'(t_max[ch][1]);
      end
    end

    dtm_div #(.SUM_W(SUM_W), .DIVISOR(WINDOW - 2)) u_div (
      .clk    (clk),
      .en_mul (stage_rdy[ST_MUL]),
      .en_out (stage_rdy[ST_OUT]),
      .rest   (rest_r[ch]),
      .quot   (quot[ch])
    );
  end

  assign out_valid          = v_r[NST-1];
  assign out_front_filtered = quot[0];
  assign out_rear_filtered  = quot[1];

endmodule

@@ rtl/dtm_cell.sv @@
// One window cell of the sample chain: one front and one rear entry.
// Depends on dtm_pkg.
module dtm_cell import dtm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    shift,
  input  sample_t d_front,
  input  sample_t d_rear,
  output sample_t q_front,
  output sample_t q_rear
);

  sample_t front_r, rear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
    end else if (shift) begin
      front_r <= d_front;
      rear_r  <= d_rear;
    end
  end

  assign q_front = front_r;
  assign q_rear  = rear_r;

endmodule

@@ rtl/dtm_node.sv @@
// Registered node of the reduction tree: merges sum, minimum and maximum
// of two children. Depends on dtm_pkg.
module dtm_node import dtm_pkg::*; #(
  parameter int SUM_W = SAMPLE_W + 3
) (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] a_sum,
  input  sample_t          a_min,
  input  sample_t          a_max,
  input  logic [SUM_W-1:0] b_sum,
  input  sample_t          b_min,
  input  sample_t          b_max,
  output logic [SUM_W-1:0] q_sum,
  output sample_t          q_min,
  output sample_t          q_max
);

  logic [SUM_W-1:0] sum_r;
  sample_t          min_r, max_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= a_sum + b_sum;
      min_r <= (a_min < b_min) ? a_min : b_min;
      max_r <= (a_max > b_max) ? a_max : b_max;
    end
  end

  assign q_sum = sum_r;
  assign q_min = min_r;
  assign q_max = max_r;

endmodule

@@ rtl/dtm_div.sv @@
// Two-stage divider by a constant: reciprocal multiply, then one
// compare-and-add correction. Depends on dtm_pkg.
module dtm_div import dtm_pkg::*; #(
  parameter int SUM_W   = SAMPLE_W + 3,
  parameter int DIVISOR = WINDOW_DEF - 2
) (
  input  logic             clk,
  input  logic             en_mul,
  input  logic             en_out,
  input  logic [SUM_W-1:0] rest,
  output sample_t          quot
);

  localparam int RECIP = (1 << MUL_SH) / DIVISOR;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = SUM_W + RW;
  localparam logic [RW-1:0]    RECIP_C = RW'(RECIP);
  localparam logic [SUM_W-1:0] DIV_C   = SUM_W'(DIVISOR);

  logic [PW-1:0]    prod;
  sample_t          q0_r;
  logic [SUM_W-1:0] rest_r;
  logic [SUM_W-1:0] rem;
  sample_t          quot_r;

  assign prod = PW'(rest) * PW'(RECIP_C);

  // The estimate is either the exact quotient or one below it.
  always_ff @(posedge clk) begin
    if (en_mul) begin
      q0_r   <= prod[MUL_SH +: SAMPLE_W];
      rest_r <= rest;
    end
  end

  assign rem = rest_r - SUM_W'(q0_r) * DIV_C;

  always_ff @(posedge clk) begin
    if (en_out) begin
      quot_r <= (rem >= DIV_C) ? q0_r + sample_t'(1) : q0_r;
    end
  end

  assign quot = quot_r;

endmodule
